[hw/rtl/cpfp_pkg.sv]
// Shared types, field codes and constants for the context packet field parser.
// Used by cpfp_seek, cpfp_outq and context_packet_field_parser; no dependencies.
package cpfp_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic        end_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  pos;
    logic [31:0] skip_add;
  } seek_res_t;

  localparam logic [3:0] KIND_BANDWIDTH   = 4'd0;
  localparam logic [3:0] KIND_IF_FREQ     = 4'd1;
  localparam logic [3:0] KIND_RF_FREQ     = 4'd2;
  localparam logic [3:0] KIND_REF_LEVEL   = 4'd3;
  localparam logic [3:0] KIND_GAIN        = 4'd4;
  localparam logic [3:0] KIND_SAMPLE_RATE = 4'd5;
  localparam logic [3:0] KIND_TEMPERATURE = 4'd6;
  localparam logic [3:0] KIND_COMPLETE    = 4'd7;
  localparam logic [3:0] KIND_SHORT_ERROR = 4'd8;

  localparam logic [4:0] POS_BANDWIDTH   = 5'd29;
  localparam logic [4:0] POS_IF_FREQ     = 5'd28;
  localparam logic [4:0] POS_RF_FREQ     = 5'd27;
  localparam logic [4:0] POS_REF_LEVEL   = 5'd24;
  localparam logic [4:0] POS_GAIN        = 5'd23;
  localparam logic [4:0] POS_SAMPLE_RATE = 5'd21;
  localparam logic [4:0] POS_TEMPERATURE = 5'd18;
  localparam logic [4:0] POS_GPS_ASCII   = 5'd9;
  localparam logic [4:0] POS_ASSOC_LIST  = 5'd8;

  localparam logic [31:0] SKIP_BITS = 32'hC65B_FF00;
  localparam int unsigned LOW_WALK_BIT = 8;

  function automatic logic [3:0] field_size(input logic [4:0] pos);
    logic [3:0] sz;
    case (pos)
      5'd30, 5'd24, 5'd23, 5'd22, 5'd19, 5'd18, 5'd16, 5'd10: sz = 4'd1;
      5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd21, 5'd20, 5'd17,
      5'd15, 5'd9, 5'd8: sz = 4'd2;
      5'd14, 5'd13: sz = 4'd11;
      5'd12, 5'd11: sz = 4'd13;
      default: sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

[hw/rtl/cpfp_seek.sv]
// Indicator walk: finds the next announced field at or below a start bit.
// Also reports the skipped-field bits passed on the way. Uses cpfp_pkg.
module cpfp_seek (
  input  logic [31:0]          presence,
  input  logic [4:0]           top,
  output cpfp_pkg::seek_res_t  res
);

  always_comb begin
    logic hit;
    hit = 1'b0;
    res = '0;
    for (int b = 31; b >= int'(cpfp_pkg::LOW_WALK_BIT); b--) begin
      if (!hit && (b <= int'(top)) && presence[b]) begin
        if (cpfp_pkg::SKIP_BITS[b]) begin
          res.skip_add[b] = 1'b1;
        end
        if (cpfp_pkg::field_size(5'(b)) != 4'd0) begin
          hit       = 1'b1;
          res.found = 1'b1;
          res.pos   = 5'(b);
        end
      end
    end
  end

endmodule

[hw/rtl/cpfp_outq.sv]
// Four-entry result queue that takes up to two beats per cycle and gives one
// while out_ready is high. Uses cpfp_pkg for the result beat type.
module cpfp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push0,
  input  logic                 push1,
  input  cpfp_pkg::out_beat_t  din0,
  input  cpfp_pkg::out_beat_t  din1,
  output logic                 room2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cpfp_pkg::out_beat_t  out_data
);

  cpfp_pkg::out_beat_t mem_r [4];
  logic [1:0] wr_r;
  logic [1:0] rd_r;
  logic [2:0] cnt_r;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = {1'b0, push0} + {1'b0, push1};
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid & out_ready;
  assign room2     = (cnt_r <= 3'd2);
  assign out_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + n_push;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, n_push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_r] <= din0;
    end
    if (push1) begin
      mem_r[wr_r + 2'd1] <= din1;
    end
  end

endmodule

[hw/rtl/context_packet_field_parser.sv]
// Top level of the context packet field parser. Uses cpfp_pkg, cpfp_seek, cpfp_outq.
// Each input beat is decoded in the cycle it is accepted and its results are queued.
// Results are registered in the result queue before they reach out_data.
// Throughput: one input beat per cycle while the queue has two free entries; it drains
// one result per cycle while out_ready is high, so two-result beats slow input.
// Reset: rst_n clears the parse state to awaiting an indicator and empties the queue.
module context_packet_field_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cpfp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cpfp_pkg::out_beat_t  out_data
);

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_FIELD,
    PH_COUNTED,
    PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] presence_r, presence_nxt;
  logic [31:0] skipped_r, skipped_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [31:0] words_left_r, words_left_nxt;
  logic [31:0] high_r, high_nxt;

  logic                 accept;
  logic                 room2;
  logic [31:0]          seek_pres;
  logic [31:0]          seek_base;
  logic [4:0]           seek_top;
  cpfp_pkg::seek_res_t  seek_res;
  logic [63:0]          wide;
  logic [63:0]          rounded;
  logic [31:0]          assoc_count;
  logic [31:0]          async_words;
  logic                 push0, push1;
  cpfp_pkg::out_beat_t  res0, res1;

  assign accept = in_valid & in_ready;
  assign in_ready = room2;

  assign seek_pres = (phase_r == PH_AWAIT) ? in_data.word : presence_r;
  assign seek_base = (phase_r == PH_AWAIT) ? 32'd0 : skipped_r;
  assign seek_top  = (phase_r == PH_AWAIT) ? 5'd31 : pos_r - 5'd1;

  cpfp_seek u_seek (
    .presence (seek_pres),
    .top      (seek_top),
    .res      (seek_res)
  );

  assign wide        = {high_r, in_data.word};
  assign rounded     = {20'd0, wide[63:20] + {43'd0, wide[19]}};
  assign async_words = in_data.word[15] ? {16'd0, in_data.word[14:0], 1'b0}
                                        : {17'd0, in_data.word[14:0]};
  assign assoc_count = async_words + {16'd0, in_data.word[31:16]}
                     + {23'd0, high_r[8:0]} + {23'd0, high_r[24:16]};

  always_comb begin
    logic        do_seek;
    logic        fr_valid;
    logic [3:0]  fr_kind;
    logic [63:0] fr_value;
    logic        cmp_valid;
    logic        err_valid;
    logic [31:0] count;
    logic [31:0] wl_dec;
    cpfp_pkg::out_beat_t fr_beat, cmp_beat, err_beat;

    phase_nxt      = phase_r;
    presence_nxt   = presence_r;
    skipped_nxt    = skipped_r;
    pos_nxt        = pos_r;
    words_left_nxt = words_left_r;
    high_nxt       = high_r;
    do_seek        = 1'b0;
    fr_valid       = 1'b0;
    fr_kind        = cpfp_pkg::KIND_BANDWIDTH;
    fr_value       = '0;
    cmp_valid      = 1'b0;
    count          = '0;
    wl_dec         = (words_left_r != 32'd0) ? words_left_r - 32'd1 : 32'd0;

    case (phase_r)
      PH_AWAIT: begin
        presence_nxt = in_data.word;
        do_seek      = 1'b1;
      end
      PH_FIELD: begin
        words_left_nxt = wl_dec;
        if (wl_dec != 32'd0) begin
          high_nxt = in_data.word;
        end else begin
          case (pos_r)
            cpfp_pkg::POS_BANDWIDTH: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_BANDWIDTH;
              fr_value = rounded;
            end
            cpfp_pkg::POS_IF_FREQ: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_IF_FREQ;
              fr_value = rounded;
            end
            cpfp_pkg::POS_RF_FREQ: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_RF_FREQ;
              fr_value = rounded;
            end
            cpfp_pkg::POS_REF_LEVEL: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_REF_LEVEL;
              fr_value = {32'd0, in_data.word};
            end
            cpfp_pkg::POS_GAIN: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_GAIN;
              fr_value = {32'd0, in_data.word};
            end
            cpfp_pkg::POS_SAMPLE_RATE: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_SAMPLE_RATE;
              fr_value = rounded;
            end
            cpfp_pkg::POS_TEMPERATURE: begin
              fr_valid = 1'b1;
              fr_kind  = cpfp_pkg::KIND_TEMPERATURE;
              fr_value = {32'd0, in_data.word};
            end
            cpfp_pkg::POS_GPS_ASCII: begin
              count = in_data.word;
            end
            cpfp_pkg::POS_ASSOC_LIST: begin
              count = assoc_count;
            end
            default: begin
            end
          endcase
          if (count != 32'd0) begin
            words_left_nxt = count;
            phase_nxt      = PH_COUNTED;
          end else begin
            do_seek = 1'b1;
          end
        end
      end
      PH_COUNTED: begin
        words_left_nxt = wl_dec;
        if (wl_dec == 32'd0) begin
          do_seek = 1'b1;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        phase_nxt = PH_AWAIT;
      end
    endcase

    if (do_seek) begin
      skipped_nxt = seek_base | seek_res.skip_add;
      if (seek_res.found) begin
        pos_nxt        = seek_res.pos;
        words_left_nxt = {28'd0, cpfp_pkg::field_size(seek_res.pos)};
        phase_nxt      = PH_FIELD;
      end else begin
        cmp_valid = 1'b1;
        phase_nxt = PH_DRAIN;
      end
    end

    err_valid = in_data.end_of_packet
              && ((phase_nxt == PH_FIELD) || (phase_nxt == PH_COUNTED));
    if (in_data.end_of_packet) begin
      phase_nxt = PH_AWAIT;
    end

    fr_beat  = '{kind: fr_kind, value: fr_value, last_of_run: 1'b0};
    cmp_beat = '{kind: cpfp_pkg::KIND_COMPLETE,
                 value: {32'd0, seek_pres & ~skipped_nxt}, last_of_run: 1'b0};
    err_beat = '{kind: cpfp_pkg::KIND_SHORT_ERROR, value: 64'd0, last_of_run: 1'b0};

    push0 = accept & (fr_valid | cmp_valid | err_valid);
    push1 = accept & fr_valid & (cmp_valid | err_valid);
    if (fr_valid) begin
      res0 = fr_beat;
    end else if (cmp_valid) begin
      res0 = cmp_beat;
    end else begin
      res0 = err_beat;
    end
    res1 = cmp_valid ? cmp_beat : err_beat;
    res0.last_of_run = ~push1;
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_AWAIT;
      presence_r   <= '0;
      skipped_r    <= '0;
      pos_r        <= 5'd31;
      words_left_r <= '0;
      high_r       <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      presence_r   <= presence_nxt;
      skipped_r    <= skipped_nxt;
      pos_r        <= pos_nxt;
      words_left_r <= words_left_nxt;
      high_r       <= high_nxt;
    end
  end

  cpfp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (res0),
    .din1      (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
